// ===== design/dcmp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dcmp_pkg: shared types and constants of the derangement counter
// Field widths, the prime modulus and the control word of the shared
// multiply-add unit.
// ----------------------------------------------------------------------------
package dcmp_pkg;

  localparam int unsigned COUNT_W = 13;
  localparam int unsigned DER_W   = 30;
  // Widest value the datapath holds: 4097 * (p - 1) stays below 2^42.
  localparam int unsigned WIDE_W  = 42;
  localparam int unsigned HIGH_W  = WIDE_W - DER_W;

  localparam logic [COUNT_W-1:0] MAX_N = COUNT_W'(4096);

  localparam logic [DER_W-1:0] PRIME = DER_W'(1000000007);
  // 2^30 mod p: folds the bits above bit 29 back into range.
  localparam logic [DER_W-1:0] FOLD_C = DER_W'(73741817);

  typedef struct packed {
    logic fold;  // 1: high * FOLD_C + low, 0: i * acc + sign term
    logic neg;   // sign term is p - 1 instead of 1
  } mac_ctrl_t;

endpackage
`default_nettype wire

// ===== design/dcmp_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dcmp_ifs: valid/ready channels of the derangement counter
// Input channel carries a count, output channel carries one result.
// ----------------------------------------------------------------------------
interface dcmp_in_if;
  logic                          valid;
  logic                          ready;
  logic [dcmp_pkg::COUNT_W-1:0]  count_n;

  modport source (output valid, output count_n, input ready);
  modport sink   (input valid, input count_n, output ready);
endinterface

interface dcmp_out_if;
  logic                        valid;
  logic                        ready;
  logic [dcmp_pkg::DER_W-1:0]  derangements;
  logic                        out_of_range;

  modport source (output valid, output derangements, output out_of_range, input ready);
  modport sink   (input valid, input derangements, input out_of_range, output ready);
endinterface
`default_nettype wire

// ===== design/dcmp_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dcmp_mac: shared multiply-add unit
// One 13x30 multiplier and a 42-bit adder, used both for the recurrence
// step and for folding the high bits back modulo p.
// ----------------------------------------------------------------------------
module dcmp_mac (
  input  var dcmp_pkg::mac_ctrl_t              ctrl_i,
  input  var logic [dcmp_pkg::COUNT_W-1:0]     idx_i,
  input  var logic [dcmp_pkg::DER_W-1:0]       acc_i,
  input  var logic [dcmp_pkg::WIDE_W-1:0]      wide_i,
  output var logic [dcmp_pkg::WIDE_W-1:0]      res_o
);

  logic [dcmp_pkg::COUNT_W-1:0]         op_a;
  logic [dcmp_pkg::DER_W-1:0]           op_b;
  logic [dcmp_pkg::WIDE_W-1:0]          addend;
  logic [dcmp_pkg::COUNT_W+dcmp_pkg::DER_W-1:0] prod;

  always_comb begin
    if (ctrl_i.fold) begin
      op_a   = {1'b0, wide_i[dcmp_pkg::WIDE_W-1:dcmp_pkg::DER_W]};
      op_b   = dcmp_pkg::FOLD_C;
      addend = {{dcmp_pkg::HIGH_W{1'b0}}, wide_i[dcmp_pkg::DER_W-1:0]};
    end else begin
      op_a   = idx_i;
      op_b   = acc_i;
      // odd step adds -1, even step adds +1
      addend = ctrl_i.neg ? {{dcmp_pkg::HIGH_W{1'b0}}, dcmp_pkg::PRIME - 1'b1}
                          : dcmp_pkg::WIDE_W'(1);
    end
    prod  = op_a * op_b;
    res_o = prod[dcmp_pkg::WIDE_W-1:0] + addend;
  end

endmodule
`default_nettype wire

// ===== design/derangement_count_mod_prime.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// derangement_count_mod_prime: derangement count modulo 1000000007
// Sequencer around one shared multiply-add unit, with an output register.
// ----------------------------------------------------------------------------
// Each item carries a count n and yields one result: D(n) mod 1000000007,
// worked as the recurrence D(i) = i*D(i-1) + (-1)^i from D(0) = 1. A count
// above 4096 is flagged with out_of_range and gives 0. Every step of the
// recurrence goes through the one 13x30 multiply-add unit: one pass forms
// i*D + sign, then further passes fold the bits above bit 29 back in
// (2^30 mod p) while any are set, and a last step does the compare and
// subtract. The block takes one item at a time; a finished result waits in
// the output register, so the next item is taken while it is not yet read.
// ----------------------------------------------------------------------------
module derangement_count_mod_prime (
  input  var logic       clk_i,
  input  var logic       rst_ni,
  dcmp_in_if.sink        in_i,
  dcmp_out_if.source     out_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_FOLD = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [dcmp_pkg::COUNT_W-1:0] n_q, n_d;
  logic [dcmp_pkg::COUNT_W-1:0] i_q, i_d;
  logic [dcmp_pkg::DER_W-1:0]   acc_q, acc_d;
  logic [dcmp_pkg::WIDE_W-1:0]  x_q, x_d;
  logic                         oor_q, oor_d;

  logic                         out_valid_q, out_valid_d;
  logic [dcmp_pkg::DER_W-1:0]   out_der_q, out_der_d;
  logic                         out_oor_q, out_oor_d;

  dcmp_pkg::mac_ctrl_t          mac_ctrl;
  logic [dcmp_pkg::WIDE_W-1:0]  mac_res;
  logic                         in_take;
  logic                         out_free;
  logic                         x_narrow;
  logic [dcmp_pkg::DER_W-1:0]   x_low;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_take    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // Fold while anything sits above bit 29; otherwise the value is below 2p.
  assign x_narrow = (x_q[dcmp_pkg::WIDE_W-1:dcmp_pkg::DER_W] == '0);
  assign x_low    = x_q[dcmp_pkg::DER_W-1:0];

  assign mac_ctrl.fold = (state_q == S_FOLD);
  assign mac_ctrl.neg  = i_q[0];

  dcmp_mac u_mac (
    .ctrl_i (mac_ctrl),
    .idx_i  (i_q),
    .acc_i  (acc_q),
    .wide_i (x_q),
    .res_o  (mac_res)
  );

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    i_d         = i_q;
    acc_d       = acc_q;
    x_d         = x_q;
    oor_d       = oor_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_der_d   = out_der_q;
    out_oor_d   = out_oor_q;

    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          n_d   = in_i.count_n;
          i_d   = dcmp_pkg::COUNT_W'(1);
          oor_d = (in_i.count_n > dcmp_pkg::MAX_N);
          if (in_i.count_n > dcmp_pkg::MAX_N) begin
            // flagged count: result is zero
            acc_d   = '0;
            state_d = S_DONE;
          end else if (in_i.count_n == '0) begin
            acc_d   = dcmp_pkg::DER_W'(1);
            state_d = S_DONE;
          end else begin
            acc_d   = dcmp_pkg::DER_W'(1);
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        // i * D(i-1) + (-1)^i
        x_d     = mac_res;
        state_d = S_FOLD;
      end
      S_FOLD: begin
        if (x_narrow) begin
          acc_d = (x_low >= dcmp_pkg::PRIME) ? (x_low - dcmp_pkg::PRIME) : x_low;
          if (i_q == n_q) begin
            state_d = S_DONE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_MUL;
          end
        end else begin
          x_d = mac_res;
        end
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (out_free) begin
          out_valid_d = 1'b1;
          out_der_d   = acc_q;
          out_oor_d   = oor_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    i_q       <= i_d;
    acc_q     <= acc_d;
    x_q       <= x_d;
    oor_q     <= oor_d;
    out_der_q <= out_der_d;
    out_oor_q <= out_oor_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.derangements = out_der_q;
  assign out_o.out_of_range = out_oor_q;

`ifndef SYNTHESIS
  // The accumulator entering a multiply is always fully reduced.
  a_acc_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL |-> acc_q < dcmp_pkg::PRIME)
    else $error("accumulator not reduced before multiply");

  // The step index never runs past the count.
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL || state_q == S_FOLD) |-> (i_q <= n_q && i_q != '0))
    else $error("step index out of bounds");

  // A flagged count goes straight to a zero result.
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && in_i.count_n > dcmp_pkg::MAX_N |=>
      state_q == S_DONE && oor_q && acc_q == '0)
    else $error("out-of-range count not flagged");

  // A flagged result always reads zero.
  a_out_oor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_oor_q |-> out_der_q == '0)
    else $error("flagged result is not zero");

  // Every fold shrinks the value.
  a_fold_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FOLD && !x_narrow |=> x_q < $past(x_q))
    else $error("fold did not shrink the value");
`endif

endmodule
`default_nettype wire
